@@ sv/jsu_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// jsu_pkg
// Shared types and constants for the JSON string unescaper: body phases,
// result kinds, error codes, the per-byte result record and hex decoding.
// ----------------------------------------------------------------------------
package jsu_pkg;

	// Where the decoder stands inside the string body.
	typedef enum logic [3:0] {
		PH_PLAIN  = 4'd0,
		PH_ESC    = 4'd1,
		PH_HEX1   = 4'd2,
		PH_WAITBS = 4'd3,
		PH_WAITU  = 4'd4,
		PH_HEX2   = 4'd5
	} phase_t;

	// Result kinds.
	localparam logic [1:0] KIND_DATA  = 2'd0;
	localparam logic [1:0] KIND_CLOSE = 2'd1;
	localparam logic [1:0] KIND_ERROR = 2'd2;

	// Error codes.
	localparam logic [2:0] ERR_BAD_ESC   = 3'd0;
	localparam logic [2:0] ERR_BAD_HEX   = 3'd1;
	localparam logic [2:0] ERR_UNP_HIGH  = 3'd2;
	localparam logic [2:0] ERR_UNP_LOW   = 3'd3;
	localparam logic [2:0] ERR_CTRL      = 3'd4;
	localparam logic [2:0] ERR_ESC_CUT   = 3'd5;
	localparam logic [2:0] ERR_UNI_CUT   = 3'd6;
	localparam logic [2:0] ERR_UNTERM    = 3'd7;

	// All results caused by one input byte, queued between front and back.
	typedef struct packed {
		logic [1:0]      kind;
		logic [2:0]      code;
		logic [1:0]      last_idx;
		logic [3:0][7:0] bytes;
	} rec_t;

	// Hex digit decode: bit 4 is set for a valid digit, bits 3:0 its value.
	function automatic logic [4:0] hex_digit(input logic [7:0] b);
		logic [4:0] r;
		r = 5'd0;
		if (b >= 8'h30 && b <= 8'h39) begin
			r = {1'b1, b[3:0]};
		end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
			r = {1'b1, b[3:0] + 4'd9};
		end
		return r;
	endfunction

endpackage
`default_nettype wire

@@ sv/jsu_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// jsu_front
// Accepts raw body bytes, tracks escapes and surrogate pairs, and turns each
// byte into at most one record of up to four results for the output queue.
// ----------------------------------------------------------------------------
module jsu_front import jsu_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] in_byte,
	input  wire logic       in_eoi,
	output logic            rec_valid,
	input  wire logic       rec_ready,
	output rec_t            rec
);

	phase_t      phase_q, phase_d;
	logic [15:0] acc_q, acc_d;
	logic [1:0]  cnt_q, cnt_d;
	logic [9:0]  hh_q, hh_d;

	logic        accept;
	logic [4:0]  hx;
	logic [15:0] acc_next;
	logic [20:0] cp;
	logic [2:0]  nd;
	logic [1:0]  ev;
	logic [2:0]  code;
	logic [3:0][7:0] by;

	// A byte is taken whenever the queue has room.
	assign in_ready = rec_ready;
	assign accept   = in_valid && in_ready;

	assign hx       = hex_digit(in_byte);
	assign acc_next = {acc_q[11:0], hx[3:0]};
	assign cp       = 21'h10000 + {1'b0, hh_q, acc_next[9:0]};

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_PLAIN;
			acc_q   <= 16'd0;
			cnt_q   <= 2'd0;
			hh_q    <= 10'd0;
		end else if (accept) begin
			phase_q <= phase_d;
			acc_q   <= acc_d;
			cnt_q   <= cnt_d;
			hh_q    <= hh_d;
		end
	end

	// Next state and the results of the current byte.
	always_comb begin
		phase_d = phase_q;
		acc_d   = acc_q;
		cnt_d   = cnt_q;
		hh_d    = hh_q;
		nd      = 3'd0;
		ev      = KIND_DATA;
		code    = ERR_BAD_ESC;
		by      = '0;
		case (phase_q)
			PH_ESC: begin
				phase_d = PH_PLAIN;
				nd = 3'd1;
				case (in_byte)
					8'h22: by[0] = 8'h22;
					8'h5C: by[0] = 8'h5C;
					8'h2F: by[0] = 8'h2F;
					8'h62: by[0] = 8'h08;
					8'h66: by[0] = 8'h0C;
					8'h6E: by[0] = 8'h0A;
					8'h72: by[0] = 8'h0D;
					8'h74: by[0] = 8'h09;
					8'h75: begin
						nd      = 3'd0;
						phase_d = PH_HEX1;
						acc_d   = 16'd0;
						cnt_d   = 2'd0;
					end
					default: begin
						nd   = 3'd0;
						ev   = KIND_ERROR;
						code = ERR_BAD_ESC;
					end
				endcase
			end
			PH_HEX1: begin
				if (!hx[4]) begin
					ev   = KIND_ERROR;
					code = ERR_BAD_HEX;
				end else begin
					acc_d = acc_next;
					if (cnt_q != 2'd3) begin
						cnt_d = cnt_q + 2'd1;
					end else begin
						cnt_d = 2'd0;
						if (acc_next[15:10] == 6'b110110) begin
							hh_d    = acc_next[9:0];
							phase_d = PH_WAITBS;
						end else if (acc_next[15:10] == 6'b110111) begin
							ev   = KIND_ERROR;
							code = ERR_UNP_LOW;
						end else begin
							phase_d = PH_PLAIN;
							if (acc_next < 16'h0080) begin
								nd    = 3'd1;
								by[0] = acc_next[7:0];
							end else if (acc_next < 16'h0800) begin
								nd    = 3'd2;
								by[0] = {3'b110, acc_next[10:6]};
								by[1] = {2'b10, acc_next[5:0]};
							end else begin
								nd    = 3'd3;
								by[0] = {4'b1110, acc_next[15:12]};
								by[1] = {2'b10, acc_next[11:6]};
								by[2] = {2'b10, acc_next[5:0]};
							end
						end
					end
				end
			end
			PH_WAITBS: begin
				if (in_byte == 8'h5C) begin
					phase_d = PH_WAITU;
				end else begin
					ev   = KIND_ERROR;
					code = ERR_UNP_HIGH;
				end
			end
			PH_WAITU: begin
				if (in_byte == 8'h75) begin
					phase_d = PH_HEX2;
					acc_d   = 16'd0;
					cnt_d   = 2'd0;
				end else begin
					ev   = KIND_ERROR;
					code = ERR_UNP_HIGH;
				end
			end
			PH_HEX2: begin
				if (!hx[4]) begin
					ev   = KIND_ERROR;
					code = ERR_UNP_HIGH;
				end else begin
					acc_d = acc_next;
					if (cnt_q != 2'd3) begin
						cnt_d = cnt_q + 2'd1;
					end else begin
						cnt_d = 2'd0;
						if (acc_next[15:10] == 6'b110111) begin
							phase_d = PH_PLAIN;
							nd      = 3'd4;
							by[0]   = {5'b11110, cp[20:18]};
							by[1]   = {2'b10, cp[17:12]};
							by[2]   = {2'b10, cp[11:6]};
							by[3]   = {2'b10, cp[5:0]};
						end else begin
							ev   = KIND_ERROR;
							code = ERR_UNP_HIGH;
						end
					end
				end
			end
			default: begin
				// Plain body; a phase code that cannot arise lands here too.
				phase_d = PH_PLAIN;
				if (in_byte == 8'h22) begin
					ev = KIND_CLOSE;
				end else if (in_byte == 8'h5C) begin
					phase_d = PH_ESC;
				end else if (in_byte < 8'h20) begin
					ev   = KIND_ERROR;
					code = ERR_CTRL;
				end else begin
					nd    = 3'd1;
					by[0] = in_byte;
				end
			end
		endcase

		// End of input with no other event: report where the body stands.
		if (ev == KIND_DATA && in_eoi) begin
			ev = KIND_ERROR;
			case (phase_d)
				PH_ESC:    code = ERR_ESC_CUT;
				PH_HEX1:   code = ERR_UNI_CUT;
				PH_WAITBS: code = ERR_UNP_HIGH;
				PH_WAITU:  code = ERR_UNP_HIGH;
				PH_HEX2:   code = ERR_UNP_HIGH;
				default:   code = ERR_UNTERM;
			endcase
		end

		// A close or an error starts a new body.
		if (ev != KIND_DATA) begin
			phase_d = PH_PLAIN;
			acc_d   = 16'd0;
			cnt_d   = 2'd0;
			hh_d    = 10'd0;
		end
	end

	// Record for the queue: one result for an event, otherwise the data bytes.
	always_comb begin
		rec.kind = ev;
		if (ev != KIND_DATA) begin
			rec.code     = (ev == KIND_ERROR) ? code : 3'd0;
			rec.last_idx = 2'd0;
			rec.bytes    = '0;
		end else begin
			rec.code     = 3'd0;
			rec.last_idx = nd[1:0] - 2'd1;
			rec.bytes    = by;
		end
	end

	assign rec_valid = in_valid && (ev != KIND_DATA || nd != 3'd0);

endmodule
`default_nettype wire

@@ sv/jsu_fifo.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// jsu_fifo
// Short register queue of result records between the decoder front and the
// output sequencer.
// ----------------------------------------------------------------------------
module jsu_fifo import jsu_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push_valid,
	output logic      push_ready,
	input  wire rec_t push_rec,
	output logic      pop_valid,
	input  wire logic pop,
	output rec_t      pop_rec
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	rec_t          mem_q [DEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [CW-1:0] cnt_q;
	logic          wr, rd;

	assign push_ready = (cnt_q != CW'(DEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign pop_rec    = mem_q[rd_q];
	assign wr         = push_valid && push_ready;
	assign rd         = pop && pop_valid;

	// Storage.
	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wr_q] <= push_rec;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
			end
			if (rd) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
			end
			if (wr && !rd) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (rd && !wr) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

endmodule
`default_nettype wire

@@ sv/jsu_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// jsu_back
// Walks the results of the record at the queue head one transfer at a time
// and marks the final result of each input byte.
// ----------------------------------------------------------------------------
module jsu_back import jsu_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        rec_valid,
	input  wire rec_t        rec,
	output logic             rec_pop,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [15:0]      m_tdata,
	output logic [1:0]       m_tuser,
	output logic             m_tlast
);

	logic [1:0] idx_q;
	logic       take;
	logic       at_last;

	assign at_last  = (idx_q == rec.last_idx);
	assign take     = m_tvalid && m_tready;
	assign rec_pop  = take && at_last;

	assign m_tvalid = rec_valid;
	assign m_tdata  = {5'd0, rec.code, rec.bytes[idx_q]};
	assign m_tuser  = rec.kind;
	assign m_tlast  = at_last;

	// Result index within the head record.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= 2'd0;
		end else if (take) begin
			idx_q <= at_last ? 2'd0 : idx_q + 2'd1;
		end
	end

endmodule
`default_nettype wire

@@ sv/json_string_unescape_utf8.sv @@
`default_nettype none
// A result is registered in the record queue before it is offered on the master side.
// Throughput: one input byte per cycle while the record queue has room; each result
// takes one output cycle while m_tready is high, so each UTF-8 byte of a \u escape is its own transfer.
// The record queue (FIFO_DEPTH entries) keeps input flowing while those bytes drain.
// Reset returns the decoder to the start of a string body and empties the queue.
// ----------------------------------------------------------------------------
// json_string_unescape_utf8
// JSON string body unescaper: raw body bytes in, UTF-8 bytes, string close
// and error results out.
// ----------------------------------------------------------------------------
module json_string_unescape_utf8 import jsu_pkg::*; #(
	parameter int FIFO_DEPTH = 4
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] in_byte
	input  wire logic        s_tlast,   // end_of_input
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [15:0]      m_tdata,   // [7:0] out_byte, [10:8] error_code
	output logic [1:0]       m_tuser,   // [1:0] out_kind
	output logic             m_tlast    // last_of_run
);

	logic f_valid, f_ready, q_valid, q_pop;
	rec_t f_rec, q_rec;

	// Decoder front.
	jsu_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_byte   (s_tdata),
		.in_eoi    (s_tlast),
		.rec_valid (f_valid),
		.rec_ready (f_ready),
		.rec       (f_rec)
	);

	// Record queue.
	jsu_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.push_rec   (f_rec),
		.pop_valid  (q_valid),
		.pop        (q_pop),
		.pop_rec    (q_rec)
	);

	// Output sequencer.
	jsu_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.rec_valid (q_valid),
		.rec       (q_rec),
		.rec_pop   (q_pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

endmodule
`default_nettype wire
